// File: rtl/tacr_pkg.sv
// Package for the text attribute color resolver: operation and register codes,
// the default palette table and the per-channel brighten and dim functions.
// Depends on nothing; imported only by the top level, not by tacr_ram.
package tacr_pkg;

  // Operation codes on op_i. The fourth code is unused and yields a zero result.
  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_WRITE   = 2'd1;
  localparam logic [1:0] OP_RESOLVE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BLINK_CAPABLE  = 2'd0;
  localparam logic [1:0] CFG_BOLD_CAPABLE   = 2'd1;
  localparam logic [1:0] CFG_DEFAULT_COLORS = 2'd2;

  localparam int unsigned RGB_W   = 24;
  localparam int unsigned INDEX_W = 26;

  typedef logic [255:0][RGB_W-1:0] palette_t;

  // Cube level: zero, or 40*k+55.
  function automatic logic [7:0] cube_level(int k);
    logic [7:0] v;
    v = (k == 0) ? 8'd0 : 8'(40 * k + 55);
    return v;
  endfunction

  // Builds the xterm default palette without any division: 16 basic colors,
  // the 6x6x6 cube walked by three nested counters, and 24 grays.
  function automatic palette_t build_palette();
    palette_t   p;
    logic [7:0] lv;
    int         n;
    p = '0;
    for (int i = 0; i < 16; i++) begin
      lv = ((i & 8) != 0) ? 8'hFF : 8'hC0;
      p[i] = {((i & 4) != 0) ? lv : 8'd0,
              ((i & 2) != 0) ? lv : 8'd0,
              ((i & 1) != 0) ? lv : 8'd0};
    end
    n = 16;
    for (int r = 0; r < 6; r++) begin
      for (int g = 0; g < 6; g++) begin
        for (int b = 0; b < 6; b++) begin
          p[n] = {cube_level(b), cube_level(g), cube_level(r)};
          n++;
        end
      end
    end
    for (int i = 0; i < 24; i++) begin
      lv = 8'(i * 10 + 8);
      p[i + 232] = {lv, lv, lv};
    end
    return p;
  endfunction

  localparam palette_t DEFAULT_PALETTE = build_palette();

  // Exact x/3 for x below 1024 by multiplication with a scaled reciprocal.
  function automatic logic [9:0] div3(logic [9:0] x);
    logic [20:0] prod;
    prod = 21'(x) * 21'd683;
    return prod[20:11];
  endfunction

  // One channel brightened: 255 from 192 up, else 85 + c*170/192,
  // computed as 85 + ((c*85) >> 5) / 3.
  function automatic logic [7:0] brighten_ch(logic [7:0] c);
    logic [14:0] p;
    logic [9:0]  q;
    p = 15'(c) * 15'd85;
    q = div3(p[14:5]);
    return (c >= 8'd192) ? 8'd255 : 8'(q + 10'd85);
  endfunction

  // One channel dimmed: c - c/3.
  function automatic logic [7:0] dim_ch(logic [7:0] c);
    logic [9:0] q;
    q = div3(10'(c));
    return c - q[7:0];
  endfunction

  function automatic logic [RGB_W-1:0] brighten_rgb(logic [RGB_W-1:0] c);
    return {brighten_ch(c[23:16]), brighten_ch(c[15:8]), brighten_ch(c[7:0])};
  endfunction

  function automatic logic [RGB_W-1:0] dim_rgb(logic [RGB_W-1:0] c);
    return {dim_ch(c[23:16]), dim_ch(c[15:8]), dim_ch(c[7:0])};
  endfunction

endpackage

// File: rtl/text_attribute_color_resolver.sv
// Top level of the text attribute color resolver: palette, cell resolve logic
// and configuration registers. Depends on tacr_pkg and tacr_ram.
//
// Usage. An item is a transfer on the command channel: it is taken at a rising
// edge where start is high and busy is low. busy stays low, so one item can be
// taken in every cycle. op_i selects a palette lookup, a palette write or the
// resolve of one character cell's foreground and background colors.
// Each item produces exactly one result. The result sits on the result ports
// marked by done_o, which is high for one cycle per item; the receiver
// cannot hold results off, so nothing here ever stalls.
// Throughput is one item per cycle: the item is registered together with the
// read of both palette ports of the RAM, and then the resolved colors are
// registered in the result register.
// Configuration is a plain write port (cfg_we_i, cfg_index_i, cfg_wdata_i)
// that takes effect at the edge where cfg_we_i is high; write it only while
// no item is in flight.
// Reset clears the configuration to zero and marks every palette entry as
// holding its xterm default, which is read from a constant table until the
// entry is first written. There is no clearing pass after reset.
module text_attribute_color_resolver
  import tacr_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Command channel.
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op_i,
  input  logic signed [25:0] fg_index_i,
  input  logic signed [25:0] bg_index_i,
  input  logic [23:0]        entry_rgb_i,
  input  logic               reverse_i,
  input  logic               blink_i,
  input  logic               bold_i,
  input  logic               dim_i,
  input  logic               blink_phase_i,
  // Result channel.
  output logic               done_o,
  output logic [23:0]        fg_rgb_o,
  output logic [23:0]        bg_rgb_o,
  output logic               fg_default_o,
  output logic               bg_default_o,
  output logic               same_as_before_o,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic               cfg_wdata_i
);

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  // Configuration registers.
  logic blink_cap_q, bold_cap_q, dflt_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_cap_q <= 1'b0;
      bold_cap_q  <= 1'b0;
      dflt_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BLINK_CAPABLE:  blink_cap_q <= cfg_wdata_i;
        CFG_BOLD_CAPABLE:   bold_cap_q  <= cfg_wdata_i;
        CFG_DEFAULT_COLORS: dflt_en_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The block never holds off a command.
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // A write hits the palette only for a non-negative index below the entry count.
  logic          wr_in_range;
  logic          pal_we;
  logic [AW-1:0] fg_addr;
  logic [AW-1:0] bg_addr;

  assign wr_in_range = !fg_index_i[25] && (fg_index_i[24:8] == '0) &&
                       ({1'b0, fg_index_i[7:0]} < 9'(PALETTE_ENTRIES));
  assign pal_we      = accept && (op_i == OP_WRITE) && wr_in_range;
  assign fg_addr     = fg_index_i[AW-1:0];
  assign bg_addr     = bg_index_i[AW-1:0];

  // One flag per entry: set once the entry has been written since reset.
  // An entry that is not yet written reads as its default from the table.
  logic [PALETTE_ENTRIES-1:0] written_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (pal_we) begin
      written_q[fg_addr] <= 1'b1;
    end
  end

  logic [23:0] ram_fg_rgb;
  logic [23:0] ram_bg_rgb;

  tacr_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i     (clk_i),
    .we_i      (pal_we),
    .waddr_i   (fg_addr),
    .wdata_i   (entry_rgb_i),
    .raddr_a_i (fg_addr),
    .raddr_b_i (bg_addr),
    .rdata_a_o (ram_fg_rgb),
    .rdata_b_o (ram_bg_rgb)
  );

  // Input register, filled at the same edge as the RAM read.
  logic               s1_valid_q;
  logic [1:0]         s1_op_q;
  logic signed [25:0] s1_fg_idx_q;
  logic signed [25:0] s1_bg_idx_q;
  logic [23:0]        s1_rgb_q;
  logic               s1_rev_q, s1_blink_q, s1_bold_q, s1_dim_q, s1_phase_q;
  logic               s1_fg_wr_q, s1_bg_wr_q;
  logic               s1_wr_hit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q     <= op_i;
      s1_fg_idx_q <= fg_index_i;
      s1_bg_idx_q <= bg_index_i;
      s1_rgb_q    <= entry_rgb_i;
      s1_rev_q    <= reverse_i;
      s1_blink_q  <= blink_i;
      s1_bold_q   <= bold_i;
      s1_dim_q    <= dim_i;
      s1_phase_q  <= blink_phase_i;
      // Old written flags, matching the old contents read from the RAM.
      s1_fg_wr_q  <= written_q[fg_addr];
      s1_bg_wr_q  <= written_q[bg_addr];
      s1_wr_hit_q <= wr_in_range;
    end
  end

  // Palette entries as they stood before this item, defaults included.
  logic [23:0] fg_pal_rgb, bg_pal_rgb;

  assign fg_pal_rgb = s1_fg_wr_q ? ram_fg_rgb : DEFAULT_PALETTE[8'(s1_fg_idx_q[AW-1:0])];
  assign bg_pal_rgb = s1_bg_wr_q ? ram_bg_rgb : DEFAULT_PALETTE[8'(s1_bg_idx_q[AW-1:0])];

  // Color of an index: negative reads as zero, 256 and up is a direct color
  // offset by 256, and a palette index beyond the entry count reads as zero.
  logic        fg_neg, bg_neg;
  logic [23:0] fg_color, bg_color;

  assign fg_neg = s1_fg_idx_q[25];
  assign bg_neg = s1_bg_idx_q[25];

  always_comb begin
    if (fg_neg) begin
      fg_color = '0;
    end else if (s1_fg_idx_q[24:8] != '0) begin
      fg_color = s1_fg_idx_q[23:0] - 24'd256;
    end else if ({1'b0, s1_fg_idx_q[7:0]} < 9'(PALETTE_ENTRIES)) begin
      fg_color = fg_pal_rgb;
    end else begin
      fg_color = '0;
    end
    if (bg_neg) begin
      bg_color = '0;
    end else if (s1_bg_idx_q[24:8] != '0) begin
      bg_color = s1_bg_idx_q[23:0] - 24'd256;
    end else if ({1'b0, s1_bg_idx_q[7:0]} < 9'(PALETTE_ENTRIES)) begin
      bg_color = bg_pal_rgb;
    end else begin
      bg_color = '0;
    end
  end

  // Cell resolve. The default flags stay with their position; a default side
  // enters the swap as color zero, which the color path already gives.
  logic        fd, bd, swap, bright_bg;
  logic [23:0] sw_fg, sw_bg, br_fg, br_bg, dm_fg, dm_bg;

  assign fd        = fg_neg && dflt_en_q;
  assign bd        = bg_neg && dflt_en_q;
  assign bright_bg = s1_blink_q && !blink_cap_q;
  assign swap      = s1_rev_q ^ (s1_blink_q && blink_cap_q && s1_phase_q);
  assign sw_fg     = swap ? bg_color : fg_color;
  assign sw_bg     = swap ? fg_color : bg_color;
  assign br_fg     = (s1_bold_q && !bold_cap_q) ? brighten_rgb(sw_fg) : sw_fg;
  assign br_bg     = bright_bg ? brighten_rgb(sw_bg) : sw_bg;
  assign dm_fg     = s1_dim_q ? dim_rgb(br_fg) : br_fg;
  assign dm_bg     = s1_dim_q ? dim_rgb(br_bg) : br_bg;

  // Result selection by operation; the unused code gives all zeros.
  logic [23:0] fg_rgb_d, bg_rgb_d;
  logic        fd_d, bd_d, same_d;

  always_comb begin
    fg_rgb_d = '0;
    bg_rgb_d = '0;
    fd_d     = 1'b0;
    bd_d     = 1'b0;
    same_d   = 1'b0;
    case (s1_op_q)
      OP_LOOKUP: begin
        fg_rgb_d = fg_color;
      end
      OP_WRITE: begin
        same_d = s1_wr_hit_q && (fg_pal_rgb == s1_rgb_q);
      end
      OP_RESOLVE: begin
        fd_d     = fd;
        bd_d     = bd;
        fg_rgb_d = fd ? 24'd0 : dm_fg;
        bg_rgb_d = bd ? 24'd0 : dm_bg;
      end
      default: ;
    endcase
  end

  // Result register.
  logic        done_q;
  logic [23:0] fg_rgb_q, bg_rgb_q;
  logic        fd_q, bd_q, same_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      fg_rgb_q <= fg_rgb_d;
      bg_rgb_q <= bg_rgb_d;
      fd_q     <= fd_d;
      bd_q     <= bd_d;
      same_q   <= same_d;
    end
  end

  assign done_o           = done_q;
  assign fg_rgb_o         = fg_rgb_q;
  assign bg_rgb_o         = bg_rgb_q;
  assign fg_default_o     = fd_q;
  assign bg_default_o     = bd_q;
  assign same_as_before_o = same_q;

endmodule

// File: rtl/tacr_ram.sv
// Generic RAM: one write port and two read ports, read data registered.
// Self-contained; used by the text attribute color resolver for its palette.
module tacr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // A read of the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
